// ----- hw/rtl/bda_pkg.sv -----
// Package for the button debounce and auto-repeat block.
// Holds sizes, register indexes, reset values and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package bda_pkg;

  // Sizes
  localparam int NUM_BUTTONS = 6;
  localparam int TIME_BITS   = 32;
  localparam int FLAG_W      = 6;
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST        = 16'd20;
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST    = 16'd400;
  localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] repeat_delay_ms;
    logic [CFG_W-1:0] repeat_interval_ms;
  } cfg_t;

  // Events one lane finds for the current request
  typedef struct packed {
    logic pressed;
    logic released;
    logic repeated;
    logic held;
  } lane_flags_t;

  typedef struct packed {
    logic [FLAG_W-1:0] pressed_flags;
    logic [FLAG_W-1:0] released_flags;
    logic [FLAG_W-1:0] repeat_flags;
    logic [FLAG_W-1:0] held_flags;
  } result_t;

endpackage

// ----- hw/rtl/bda_if.sv -----
// Stream interfaces for the button debounce and auto-repeat block.
// Input samples and result flags, each with valid and ready.
// Depends on bda_pkg for the field widths.
`timescale 1ns / 1ps

interface bda_in_if;
  logic                        valid;
  logic                        ready;
  logic [bda_pkg::FLAG_W-1:0]  raw_levels;
  logic [bda_pkg::NOW_W-1:0]   now_ms;

  modport source  (output valid, output raw_levels, output now_ms, input ready);
  modport sink    (input valid, input raw_levels, input now_ms, output ready);
  modport monitor (input valid, input raw_levels, input now_ms, input ready);
endinterface

interface bda_out_if;
  logic                       valid;
  logic                       ready;
  logic [bda_pkg::FLAG_W-1:0] pressed_flags;
  logic [bda_pkg::FLAG_W-1:0] released_flags;
  logic [bda_pkg::FLAG_W-1:0] repeat_flags;
  logic [bda_pkg::FLAG_W-1:0] held_flags;

  modport source  (output valid, output pressed_flags, output released_flags,
                   output repeat_flags, output held_flags, input ready);
  modport sink    (input valid, input pressed_flags, input released_flags,
                   input repeat_flags, input held_flags, output ready);
  modport monitor (input valid, input pressed_flags, input released_flags,
                   input repeat_flags, input held_flags, input ready);
endinterface

// ----- hw/rtl/bda_lane.sv -----
// One button lane: raw and debounced level plus the three timestamps.
// Computes the events of one request and updates its state on accept.
// Depends on bda_pkg.
`timescale 1ns / 1ps

module bda_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  raw_i,
  input  bda_pkg::time_t        now_i,
  input  bda_pkg::cfg_t         cfg_i,
  output bda_pkg::lane_flags_t  flags_o
);
  import bda_pkg::*;

  logic  raw_q, raw_d;
  logic  stable_q, stable_d;
  time_t change_q, change_d;
  time_t press_q, press_d;
  time_t last_q, last_d;

  logic  raw_changed;
  time_t since_change;
  time_t since_press;
  time_t since_repeat;
  logic  take;
  logic  press_evt;
  logic  release_evt;
  logic  held;
  logic  repeat_evt;
  time_t last_base;

  always_comb begin
    // Restart debounce time on a raw change
    raw_changed  = raw_i != raw_q;
    raw_d        = raw_i;
    change_d     = raw_changed ? now_i : change_q;
    since_change = raw_changed ? '0 : time_t'(now_i - change_q);

    // Accept the raw level once it has held long enough
    take        = (since_change >= time_t'(cfg_i.debounce_ms)) && (stable_q != raw_i);
    stable_d    = take ? raw_i : stable_q;
    press_evt   = take && !raw_i;
    release_evt = take && raw_i;

    // A press restarts the repeat timing
    press_d      = press_evt ? now_i : press_q;
    last_base    = press_evt ? now_i : last_q;
    since_press  = press_evt ? '0 : time_t'(now_i - press_q);
    since_repeat = press_evt ? '0 : time_t'(now_i - last_q);

    // Fire a repeat while held past the delay and the interval
    held       = !stable_d;
    repeat_evt = held && (since_press >= time_t'(cfg_i.repeat_delay_ms))
                      && (since_repeat >= time_t'(cfg_i.repeat_interval_ms));
    last_d     = repeat_evt ? now_i : last_base;

    flags_o.pressed  = press_evt;
    flags_o.released = release_evt;
    flags_o.repeated = repeat_evt;
    flags_o.held     = held;
  end

  // Hold lane state, advance on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b1;
      stable_q <= 1'b1;
      change_q <= '0;
      press_q  <= '0;
      last_q   <= '0;
    end else if (accept_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      change_q <= change_d;
      press_q  <= press_d;
      last_q   <= last_d;
    end
  end

endmodule

// ----- hw/rtl/bda_merge.sv -----
// Merging stage: packs the lane flags into one result and buffers it.
// Two-entry buffer so a new request is taken while a result waits.
// Depends on bda_pkg and bda_out_if.
`timescale 1ns / 1ps

module bda_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bda_pkg::lane_flags_t lanes_i [bda_pkg::NUM_BUTTONS],
  output logic                 ready_o,
  bda_out_if.source            out_o
);
  import bda_pkg::*;

  result_t    merged;
  result_t    slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  // Combine lane flags; buttons past the field width are dropped
  always_comb begin
    merged = '0;
    for (int i = 0; i < FLAG_W; i++) begin
      if (i < NUM_BUTTONS) begin
        merged.pressed_flags[i]  = lanes_i[i].pressed;
        merged.released_flags[i] = lanes_i[i].released;
        merged.repeat_flags[i]   = lanes_i[i].repeated;
        merged.held_flags[i]     = lanes_i[i].held;
      end
    end
  end

  assign ready_o = count_q != 2'd2;
  assign pop     = out_o.valid && out_o.ready;

  always_comb begin
    wr_d    = push_i ? !wr_q : wr_q;
    rd_d    = pop ? !rd_q : rd_q;
    count_d = count_q + 2'(push_i) - 2'(pop);
  end

  // Hold buffer pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Store the merged result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= merged;
    end
  end

  assign out_o.valid          = count_q != 2'd0;
  assign out_o.pressed_flags  = slot_q[rd_q].pressed_flags;
  assign out_o.released_flags = slot_q[rd_q].released_flags;
  assign out_o.repeat_flags   = slot_q[rd_q].repeat_flags;
  assign out_o.held_flags     = slot_q[rd_q].held_flags;

endmodule

// ----- hw/rtl/button_debounce_autorepeat_top.sv -----
// Top level of the button debounce and auto-repeat block.
// Depends on bda_pkg, bda_if, bda_lane and bda_merge.
//
// Takes one pin sample per request, every clock cycle, and gives one result
// per sample from a registered buffer. Each button has its own lane with its
// debounce and repeat timers; all lanes update on the same accepted request and
// a merging stage packs their flags into a two-entry output buffer, so input is
// taken while a result waits and stalls only once two results are pending.
// After reset every button reads as released and all timestamps are zero.
// Configuration writes take effect on the next sample and should be made
// while no result is pending.
`timescale 1ns / 1ps

module button_debounce_autorepeat_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bda_pkg::CFG_W-1:0]      cfg_data_i,
  bda_in_if.sink                         in_i,
  bda_out_if.source                      out_o
);
  import bda_pkg::*;

  cfg_t        cfg_q, cfg_d;
  logic        accept;
  logic        merge_ready;
  time_t       now;
  lane_flags_t lane_flags [NUM_BUTTONS];

  // Decode configuration writes; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:        cfg_d.debounce_ms        = cfg_data_i;
        REG_REPEAT_DELAY:    cfg_d.repeat_delay_ms    = cfg_data_i;
        REG_REPEAT_INTERVAL: cfg_d.repeat_interval_ms = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms        <= DEBOUNCE_RST;
      cfg_q.repeat_delay_ms    <= REPEAT_DELAY_RST;
      cfg_q.repeat_interval_ms <= REPEAT_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_i.ready = merge_ready;
  assign accept     = in_i.valid && merge_ready;
  assign now        = in_i.now_ms[TIME_BITS-1:0];

  // One lane per button; buttons beyond the field see a low raw level
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic raw;
    if (g < FLAG_W) begin : g_pin
      assign raw = in_i.raw_levels[g];
    end else begin : g_none
      assign raw = 1'b0;
    end
    bda_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (accept),
      .raw_i    (raw),
      .now_i    (now),
      .cfg_i    (cfg_q),
      .flags_o  (lane_flags[g])
    );
  end

  bda_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .lanes_i (lane_flags),
    .ready_o (merge_ready),
    .out_o   (out_o)
  );

endmodule

// ----- hw/rtl/bda_checker.sv -----
// Port-level checks for the button debounce and auto-repeat block.
// Bound to button_debounce_autorepeat_top; depends on bda_pkg.
`timescale 1ns / 1ps

module bda_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bda_pkg::FLAG_W-1:0] pressed_i,
  input logic [bda_pkg::FLAG_W-1:0] released_i,
  input logic [bda_pkg::FLAG_W-1:0] repeat_i,
  input logic [bda_pkg::FLAG_W-1:0] held_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A press leaves the button held
  a_press_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pressed_i & ~held_i) == '0)
    else $error("press without held");

  // A release leaves the button not held
  a_release_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (released_i & held_i) == '0)
    else $error("release while held");

  // Repeats fire only while held
  a_repeat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (repeat_i & ~held_i) == '0)
    else $error("repeat without held");

endmodule

bind button_debounce_autorepeat_top bda_checker u_bda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pressed_i   (out_o.pressed_flags),
  .released_i  (out_o.released_flags),
  .repeat_i    (out_o.repeat_flags),
  .held_i      (out_o.held_flags)
);

// ----- tb/bda_flag_checker.sv -----
// Flag checker for the button debounce and auto-repeat block.
// Mirrors the per-button debounce and repeat timing, checks every result.
// Depends on bda_pkg and bda_if.
`timescale 1ns / 1ps

module bda_flag_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bda_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bda_pkg::CFG_W-1:0]     cfg_data_i,
  bda_in_if.monitor                     smp_i,
  bda_out_if.monitor                    flg_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            checked_o,
  output int                            presses_o,
  output int                            releases_o,
  output int                            repeats_o
);
  import bda_pkg::*;

  // Mirrored registers and per-button timing state
  cfg_t                   cfg_q;
  logic [NUM_BUTTONS-1:0] raw_q;
  logic [NUM_BUTTONS-1:0] stable_q;
  time_t                  change_t [NUM_BUTTONS];
  time_t                  press_t  [NUM_BUTTONS];
  time_t                  repeat_t [NUM_BUTTONS];

  // Flags due for requests already taken, oldest first
  result_t flags_due_q [$];

  // Advance every button by one pin sample and work out the flags it gives
  task automatic step_buttons(input logic [FLAG_W-1:0] lv, input time_t now,
                              output result_t r);
    time_t since_change;
    time_t since_press;
    time_t since_repeat;
    r = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      // restart the debounce time on any raw change
      if (lv[b] != raw_q[b]) begin
        raw_q[b]    = lv[b];
        change_t[b] = now;
      end
      since_change = now - change_t[b];
      if (since_change >= time_t'(cfg_q.debounce_ms) && stable_q[b] != raw_q[b]) begin
        stable_q[b] = raw_q[b];
        if (!stable_q[b]) begin
          r.pressed_flags[b] = 1'b1;
          press_t[b]         = now;
          repeat_t[b]        = now;
        end else begin
          r.released_flags[b] = 1'b1;
        end
      end
      // fire a repeat once past the delay, at most once per interval
      if (!stable_q[b]) begin
        r.held_flags[b] = 1'b1;
        since_press     = now - press_t[b];
        since_repeat    = now - repeat_t[b];
        if (since_press >= time_t'(cfg_q.repeat_delay_ms) &&
            since_repeat >= time_t'(cfg_q.repeat_interval_ms)) begin
          r.repeat_flags[b] = 1'b1;
          repeat_t[b]       = now;
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [FLAG_W-1:0] want,
                             input logic [FLAG_W-1:0] got);
    if (want !== got) begin
      mismatches_o++;
      if (mismatches_o <= 10)
        $display("%0t: %s mismatch: expected %02h, got %02h", $realtime, what, want, got);
    end
  endtask

  // Sample at the falling edge: every handshake seen here completes on the next rising edge
  always @(negedge clk_i) begin : watch
    result_t want;
    result_t got;
    if (!rst_ni) begin
      cfg_q.debounce_ms        = DEBOUNCE_RST;
      cfg_q.repeat_delay_ms    = REPEAT_DELAY_RST;
      cfg_q.repeat_interval_ms = REPEAT_INTERVAL_RST;
      raw_q    = '1;
      stable_q = '1;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        change_t[b] = '0;
        press_t[b]  = '0;
        repeat_t[b] = '0;
      end
      flags_due_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      presses_o    = 0;
      releases_o   = 0;
      repeats_o    = 0;
    end else begin
      // predict before retiring, in case a result leaves with its own request
      if (smp_i.valid && smp_i.ready) begin
        step_buttons(smp_i.raw_levels, smp_i.now_ms, want);
        flags_due_q.push_back(want);
      end
      if (flg_i.valid && flg_i.ready) begin
        got.pressed_flags  = flg_i.pressed_flags;
        got.released_flags = flg_i.released_flags;
        got.repeat_flags   = flg_i.repeat_flags;
        got.held_flags     = flg_i.held_flags;
        if (flags_due_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result %h arrived with no request outstanding", $realtime, got);
        end else begin
          want = flags_due_q.pop_front();
          check_field("pressed_flags", want.pressed_flags, got.pressed_flags);
          check_field("released_flags", want.released_flags, got.released_flags);
          check_field("repeat_flags", want.repeat_flags, got.repeat_flags);
          check_field("held_flags", want.held_flags, got.held_flags);
          checked_o++;
          presses_o  += $countones(want.pressed_flags);
          releases_o += $countones(want.released_flags);
          repeats_o  += $countones(want.repeat_flags);
        end
      end
      // register writes apply from the next request on
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE:        cfg_q.debounce_ms        = cfg_data_i;
          REG_REPEAT_DELAY:    cfg_q.repeat_delay_ms    = cfg_data_i;
          REG_REPEAT_INTERVAL: cfg_q.repeat_interval_ms = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = flags_due_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the debounce and auto-repeat testbench: clock, reset, stimulus, verdict.
// Drives pin samples and register writes, leaves prediction to bda_flag_checker.
// Depends on bda_pkg, bda_if, bda_flag_checker and button_debounce_autorepeat_top.
`timescale 1ns / 1ps

module testbench;
  import bda_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 108;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int src_idle_pct = 15;
  int snk_idle_pct = 59;
  int sent;
  int settings;
  int step_max;
  logic [FLAG_W-1:0] hold_tgt;
  time_t             clock_ms;

  int mismatches, pending, checked, presses, releases, repeats;

  bda_in_if  in_if ();
  bda_out_if out_if ();

  button_debounce_autorepeat_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  bda_flag_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .smp_i        (in_if),
    .flg_i        (out_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .presses_o    (presses),
    .releases_o   (releases),
    .repeats_o    (repeats)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Hold off a sample at random, then present it until taken
  task automatic send_sample(input logic [FLAG_W-1:0] lv, input time_t t);
    logic took;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_levels <= lv;
    in_if.now_ms     <= t;
    do begin
      @(negedge clk_i);
      took = in_if.ready;
      @(posedge clk_i);
    end while (!took);
    sent++;
  endtask

  // Stop sending and wait until every result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] dbnc, input logic [CFG_W-1:0] dly,
                          input logic [CFG_W-1:0] ivl);
    drain();
    write_reg(REG_DEBOUNCE, dbnc);
    write_reg(REG_REPEAT_DELAY, dly);
    write_reg(REG_REPEAT_INTERVAL, ivl);
    cfg_we <= 1'b0;
    settings++;
    // scale time steps so presses last through several repeats
    step_max = ((int'(dbnc) + int'(dly) + 2 * int'(ivl)) >> 3) + 1;
  endtask

  // Mostly steady presses with contact bounce, some noise and time jumps
  task automatic random_sample();
    logic [FLAG_W-1:0] lv;
    logic [FLAG_W-1:0] bounce;
    int pick;
    pick = $urandom_range(99);
    if (pick < 4) begin
      lv       = FLAG_W'($urandom);
      clock_ms = $urandom;
    end else begin
      if (pick < 7) clock_ms -= $urandom_range(40);
      else          clock_ms += $urandom_range(step_max);
      for (int b = 0; b < FLAG_W; b++) begin
        if ($urandom_range(99) < 4) hold_tgt[b] = ~hold_tgt[b];
        bounce[b] = ($urandom_range(99) < 8);
      end
      lv = hold_tgt ^ bounce;
    end
    send_sample(lv, clock_ms);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] dbnc, dly, ivl;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.raw_levels = '1;
    in_if.now_ms     = '0;
    hold_tgt         = '1;
    clock_ms         = '0;
    sent             = 0;
    settings         = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset timing: debounce edge, repeat delay edge, repeat interval
    send_sample(6'h3F, 32'd0);
    send_sample(6'h00, 32'd5);
    send_sample(6'h00, 32'd24);
    send_sample(6'h00, 32'd25);
    send_sample(6'h00, 32'd424);
    send_sample(6'h00, 32'd425);
    send_sample(6'h00, 32'd525);
    // bounce on alternate buttons, then staggered releases
    send_sample(6'h15, 32'd530);
    send_sample(6'h2A, 32'd540);
    send_sample(6'h3F, 32'd560);
    send_sample(6'h3F, 32'd580);
    // debounce across the wrap of the millisecond counter
    send_sample(6'h00, 32'hFFFF_FFF0);
    send_sample(6'h00, 32'h0000_0004);
    send_sample(6'h3F, 32'h8000_000F);
    send_sample(6'h3F, 32'hFFFF_FFFF);

    // Zero timing: press and repeat together, then a repeat every sample
    set_regs('0, '0, '0);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    cfg_we <= 1'b0;
    send_sample(6'h3E, 32'd0);
    send_sample(6'h3E, 32'd0);
    send_sample(6'h3F, 32'd1);

    // Longest timing on every register
    set_regs('1, '1, '1);
    send_sample(6'h1F, 32'd100);
    send_sample(6'h1F, 32'd100 + 32'd65534);
    send_sample(6'h1F, 32'd100 + 32'd65535);
    send_sample(6'h1F, 32'd100 + 32'd131070);
    clock_ms = 32'd200000;

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: {dbnc, dly, ivl} = {DEBOUNCE_RST, REPEAT_DELAY_RST, REPEAT_INTERVAL_RST};
        1: {dbnc, dly, ivl} = {16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: {dbnc, dly, ivl} = '0;
        3: {dbnc, dly, ivl} = {16'd0, 16'hFFFF, 16'd1};
        default: begin
          if (ph % 2 == 1) begin
            dbnc = CFG_W'($urandom_range(15));
            dly  = CFG_W'($urandom_range(60));
            ivl  = CFG_W'($urandom_range(20));
          end else begin
            dbnc = CFG_W'($urandom);
            dly  = CFG_W'($urandom);
            ivl  = CFG_W'($urandom);
          end
        end
      endcase
      if (ph < 4) begin
        src_idle_pct = 15;
        snk_idle_pct = 59;
      end else if (ph < 8) begin
        src_idle_pct = 59;
        snk_idle_pct = 15;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_regs(dbnc, dly, ivl);
      for (int i = 0; i < PHASE_ITEMS; i++) random_sample();
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("%0d pin samples under %0d register settings, %0d results checked",
             sent, settings, checked);
    $display("flags seen: %0d presses, %0d releases, %0d repeats", presses, releases, repeats);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3_000_000;
    $display("run timed out with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
